### rtl/core/gbp_pkg.sv
// Shared types and constants for the gshare branch predictor with target buffer.
package gbp_pkg;

   localparam int unsigned CTR_DEPTH   = 1024;
   localparam int unsigned TGT_DEPTH   = 512;
   localparam int unsigned ADDR_BITS   = 32;
   localparam int unsigned HIST_BITS   = 63;
   localparam int unsigned HLEN_BITS   = 6;
   localparam int unsigned CNT_BITS    = 32;
   localparam int unsigned CSR_IDX_W   = 4;
   localparam int unsigned CSR_DATA_W  = 6;

   localparam int unsigned PHT_IDX_W   = $clog2(CTR_DEPTH);
   localparam int unsigned BTB_IDX_W   = $clog2(TGT_DEPTH);
   localparam int unsigned CLR_ENTRIES =
      (CTR_DEPTH > TGT_DEPTH) ? CTR_DEPTH : TGT_DEPTH;
   localparam int unsigned CLR_IDX_W   = $clog2(CLR_ENTRIES);

   localparam logic [1:0] CTR_WEAK_NT   = 2'b01;
   localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
   localparam logic [1:0] CTR_MAX       = 2'd3;
   localparam logic [1:0] CTR_MIN       = 2'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_PERFECT_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_LENGTH = CSR_IDX_W'(1);

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] target;
   } btb_entry_type;

   typedef struct packed {
      logic                 en;
      logic [PHT_IDX_W-1:0] pht_idx;
      logic [BTB_IDX_W-1:0] btb_idx;
   } tbl_rd_type;

   typedef struct packed {
      logic                 pht_we;
      logic [PHT_IDX_W-1:0] pht_idx;
      logic [1:0]           pht_data;
      logic                 btb_we;
      logic [BTB_IDX_W-1:0] btb_idx;
      btb_entry_type        btb_data;
   } tbl_wr_type;

endpackage

### rtl/core/gbp_tables.sv
// Direction counter and target buffer memories with the post-reset clearing pass.
module gbp_tables (
   input  logic                  clock,
   input  logic                  reset,
   input  gbp_pkg::tbl_rd_type   rd,
   input  gbp_pkg::tbl_wr_type   wr,
   output logic                  ready,
   output logic [1:0]            pht_q,
   output gbp_pkg::btb_entry_type btb_q
);

   logic [1:0]             pht_mem [gbp_pkg::CTR_DEPTH];
   gbp_pkg::btb_entry_type btb_mem [gbp_pkg::TGT_DEPTH];

   logic                            clearing_ff, clearing_in;
   logic [gbp_pkg::CLR_IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic [1:0]                      pht_q_ff;
   gbp_pkg::btb_entry_type          btb_q_ff;
   gbp_pkg::tbl_wr_type             wr_mux;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + gbp_pkg::CLR_IDX_W'(1);
         if (clr_idx_ff == gbp_pkg::CLR_IDX_W'(gbp_pkg::CLR_ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         wr_mux.pht_we          = 1'b1;
         wr_mux.pht_idx         = clr_idx_ff[gbp_pkg::PHT_IDX_W-1:0];
         wr_mux.pht_data        = gbp_pkg::CTR_WEAK_NT;
         wr_mux.btb_we          = 1'b1;
         wr_mux.btb_idx         = clr_idx_ff[gbp_pkg::BTB_IDX_W-1:0];
         wr_mux.btb_data.valid  = 1'b0;
         wr_mux.btb_data.target = '0;
      end else begin
         wr_mux = wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mux.pht_we) begin
         pht_mem[wr_mux.pht_idx] <= wr_mux.pht_data;
      end
      if (rd.en) begin
         pht_q_ff <= pht_mem[rd.pht_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mux.btb_we) begin
         btb_mem[wr_mux.btb_idx] <= wr_mux.btb_data;
      end
      if (rd.en) begin
         btb_q_ff <= btb_mem[rd.btb_idx];
      end
   end

   assign ready = !clearing_ff;
   assign pht_q = pht_q_ff;
   assign btb_q = btb_q_ff;

endmodule

### rtl/core/gshare_branch_predictor_btb.sv
// Top level of the gshare branch predictor with direct-mapped target buffer.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/ready   branch_pc, was_taken, branch_target
//   rsp      out        rsp_valid/ready   predicted_right, branch_count, mispredict_count
//   csr      in         csr_we            csr_index, csr_wdata
//
// The counter and target buffer are read at accept and written back when the item
// finishes in S_EXEC; the next beat is taken only once the block is back in S_IDLE.
// After reset a clearing pass sweeps both memories; req_ready stays low until it ends.
// A result held by rsp_ready low stalls the update cycle of the next item only.
module gshare_branch_predictor_btb (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gbp_pkg::ADDR_BITS-1:0]   req_branch_pc,
   input  logic                            req_was_taken,
   input  logic [gbp_pkg::ADDR_BITS-1:0]   req_branch_target,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_predicted_right,
   output logic [gbp_pkg::CNT_BITS-1:0]    rsp_branch_count,
   output logic [gbp_pkg::CNT_BITS-1:0]    rsp_mispredict_count,
   input  logic                            csr_we,
   input  logic [gbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type                          state_ff, state_in;
   logic                               perfect_ff, perfect_in;
   logic [gbp_pkg::HLEN_BITS-1:0]      hlen_ff, hlen_in;
   logic [gbp_pkg::HIST_BITS-1:0]      hist_ff, hist_in;
   logic [gbp_pkg::CNT_BITS-1:0]       branches_ff, branches_in;
   logic [gbp_pkg::CNT_BITS-1:0]       misses_ff, misses_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               right_ff, right_in;
   logic [gbp_pkg::ADDR_BITS-1:0]      pc_ff, target_ff;
   logic                               taken_ff;

   gbp_pkg::tbl_rd_type                tbl_rd;
   gbp_pkg::tbl_wr_type                tbl_wr;
   logic                               tbl_ready;
   logic [1:0]                         pht_q;
   gbp_pkg::btb_entry_type             btb_q;

   logic                               accept, finish, guess, right;
   logic [1:0]                         ctr_next;
   logic [gbp_pkg::HIST_BITS-1:0]      hist_mask, csr_mask;

   gbp_tables u_tables (
      .clock (clock),
      .reset (reset),
      .rd    (tbl_rd),
      .wr    (tbl_wr),
      .ready (tbl_ready),
      .pht_q (pht_q),
      .btb_q (btb_q)
   );

   assign req_ready = (state_ff == S_IDLE) && tbl_ready;
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign hist_mask = gbp_pkg::HIST_BITS'((64'd1 << hlen_ff) - 64'd1);
   assign csr_mask  = gbp_pkg::HIST_BITS'(
      (64'd1 << csr_wdata[gbp_pkg::HLEN_BITS-1:0]) - 64'd1);

   always_comb begin
      tbl_rd.en      = accept;
      tbl_rd.pht_idx = req_branch_pc[gbp_pkg::PHT_IDX_W-1:0]
                     ^ hist_ff[gbp_pkg::PHT_IDX_W-1:0];
      tbl_rd.btb_idx = req_branch_pc[gbp_pkg::BTB_IDX_W-1:0];
   end

   always_comb begin
      guess = pht_q >= gbp_pkg::CTR_TAKEN_MIN;
      right = (guess == taken_ff);
      if (right && taken_ff && (!btb_q.valid || btb_q.target != target_ff)) begin
         right = 1'b0;
      end
      if (perfect_ff) begin
         right = 1'b1;
      end
      if (taken_ff) begin
         ctr_next = (pht_q == gbp_pkg::CTR_MAX) ? pht_q : pht_q + 2'd1;
      end else begin
         ctr_next = (pht_q == gbp_pkg::CTR_MIN) ? pht_q : pht_q - 2'd1;
      end
   end

   always_comb begin
      tbl_wr.pht_we          = finish && !perfect_ff;
      tbl_wr.pht_idx         = pc_ff[gbp_pkg::PHT_IDX_W-1:0]
                             ^ hist_ff[gbp_pkg::PHT_IDX_W-1:0];
      tbl_wr.pht_data        = ctr_next;
      tbl_wr.btb_we          = finish && !perfect_ff && taken_ff;
      tbl_wr.btb_idx         = pc_ff[gbp_pkg::BTB_IDX_W-1:0];
      tbl_wr.btb_data.valid  = 1'b1;
      tbl_wr.btb_data.target = target_ff;
   end

   always_comb begin
      state_in     = state_ff;
      perfect_in   = perfect_ff;
      hlen_in      = hlen_ff;
      hist_in      = hist_ff;
      branches_in  = branches_ff;
      misses_in    = misses_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      right_in     = right_ff;
      if (csr_we) begin
         unique case (csr_index)
            gbp_pkg::CSR_PERFECT_MODE: begin
               perfect_in = csr_wdata[0];
            end
            gbp_pkg::CSR_HISTORY_LENGTH: begin
               hlen_in = csr_wdata[gbp_pkg::HLEN_BITS-1:0];
               hist_in = hist_ff & csr_mask;
            end
            default: begin
            end
         endcase
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               right_in     = right;
               branches_in  = branches_ff + gbp_pkg::CNT_BITS'(1);
               if (!right) begin
                  misses_in = misses_ff + gbp_pkg::CNT_BITS'(1);
               end
               if (!perfect_ff) begin
                  hist_in = {hist_ff[gbp_pkg::HIST_BITS-2:0], taken_ff} & hist_mask;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         perfect_ff   <= 1'b0;
         hlen_ff      <= '0;
         hist_ff      <= '0;
         branches_ff  <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         right_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         perfect_ff   <= perfect_in;
         hlen_ff      <= hlen_in;
         hist_ff      <= hist_in;
         branches_ff  <= branches_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
         right_ff     <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pc_ff     <= req_branch_pc;
         taken_ff  <= req_was_taken;
         target_ff <= req_branch_target;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_right  = right_ff;
   assign rsp_branch_count     = branches_ff;
   assign rsp_mispredict_count = misses_ff;

   a_branch_step: assert property (@(posedge clock) disable iff (reset)
      finish |=> branches_ff == $past(branches_ff) + gbp_pkg::CNT_BITS'(1))
      else $error("branch count did not advance by one");

   a_miss_hold: assert property (@(posedge clock) disable iff (reset)
      (!finish || right) |=> $stable(misses_ff))
      else $error("mispredict count moved without a miss");

   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr.pht_we || tbl_wr.btb_we) |-> tbl_ready)
      else $error("table update during clearing pass");

   a_perfect_right: assert property (@(posedge clock) disable iff (reset)
      (finish && perfect_ff) |=> right_ff && $stable(hist_ff))
      else $error("perfect mode changed history or missed");

endmodule

### tb/tb_gshare_branch_predictor_btb.sv
// Self-checking testbench for the gshare branch predictor with target buffer.
module tb_gshare_branch_predictor_btb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOT_BRANCHES = 16;
   localparam int unsigned CSR_FIRST_UNUSED = gbp_pkg::CSR_HISTORY_LENGTH + 1;

   typedef struct packed {
      logic                         predicted_right;
      logic [gbp_pkg::CNT_BITS-1:0] branch_count;
      logic [gbp_pkg::CNT_BITS-1:0] mispredict_count;
   } branch_outcome_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [gbp_pkg::ADDR_BITS-1:0]  req_branch_pc;
   logic                           req_was_taken;
   logic [gbp_pkg::ADDR_BITS-1:0]  req_branch_target;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_predicted_right;
   logic [gbp_pkg::CNT_BITS-1:0]   rsp_branch_count;
   logic [gbp_pkg::CNT_BITS-1:0]   rsp_mispredict_count;
   logic                           csr_we;
   logic [gbp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gbp_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor copy
   logic [1:0]                    pht_ctr    [gbp_pkg::CTR_DEPTH];
   logic [gbp_pkg::ADDR_BITS-1:0] btb_target [gbp_pkg::TGT_DEPTH];
   logic                          btb_valid  [gbp_pkg::TGT_DEPTH];
   logic [gbp_pkg::HIST_BITS-1:0] ghr;
   logic [gbp_pkg::CNT_BITS-1:0]  seen_count;
   logic [gbp_pkg::CNT_BITS-1:0]  miss_count;
   logic                          perfect_on;
   logic [gbp_pkg::HLEN_BITS-1:0] hist_len;

   branch_outcome_type pending_results[$];
   int                 fail_count = 0;
   bit                 quiet = 1'b0;
   int                 rsp_stall = 0;

   gshare_branch_predictor_btb u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_branch_pc        (req_branch_pc),
      .req_was_taken        (req_was_taken),
      .req_branch_target    (req_branch_target),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_predicted_right  (rsp_predicted_right),
      .rsp_branch_count     (rsp_branch_count),
      .rsp_mispredict_count (rsp_mispredict_count),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [gbp_pkg::HIST_BITS-1:0] hist_mask(
      input logic [gbp_pkg::HLEN_BITS-1:0] len);
      logic [gbp_pkg::HIST_BITS:0] one_hot;
      one_hot    = '0;
      one_hot[0] = 1'b1;
      one_hot    = one_hot << len;
      one_hot    = one_hot - 1'b1;
      return one_hot[gbp_pkg::HIST_BITS-1:0];
   endfunction

   function automatic void reset_model();
      foreach (pht_ctr[i]) pht_ctr[i] = gbp_pkg::CTR_WEAK_NT;
      foreach (btb_target[i]) begin
         btb_target[i] = '0;
         btb_valid[i]  = 1'b0;
      end
      ghr        = '0;
      seen_count = '0;
      miss_count = '0;
      perfect_on = 1'b0;
      hist_len   = '0;
   endfunction

   function automatic void apply_csr(input logic [gbp_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [gbp_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         gbp_pkg::CSR_PERFECT_MODE: perfect_on = data[0];
         gbp_pkg::CSR_HISTORY_LENGTH: begin
            hist_len = data[gbp_pkg::HLEN_BITS-1:0];
            ghr      = ghr & hist_mask(data[gbp_pkg::HLEN_BITS-1:0]);
         end
         default: ;
      endcase
   endfunction

   function automatic branch_outcome_type resolve_branch(
      input logic [gbp_pkg::ADDR_BITS-1:0] pc,
      input logic                          taken,
      input logic [gbp_pkg::ADDR_BITS-1:0] target);
      branch_outcome_type            res;
      logic [gbp_pkg::HIST_BITS-1:0] hashed;
      logic [gbp_pkg::PHT_IDX_W-1:0] pi;
      logic [gbp_pkg::BTB_IDX_W-1:0] bi;
      logic [1:0]                    ctr;
      logic                          right;
      seen_count = seen_count + gbp_pkg::CNT_BITS'(1);
      if (perfect_on) begin
         right = 1'b1;
      end else begin
         hashed = gbp_pkg::HIST_BITS'(pc) ^ ghr;
         pi     = hashed[gbp_pkg::PHT_IDX_W-1:0];
         bi     = pc[gbp_pkg::BTB_IDX_W-1:0];
         ctr    = pht_ctr[pi];
         right  = ((ctr >= gbp_pkg::CTR_TAKEN_MIN) == taken);
         if (right && taken && (!btb_valid[bi] || btb_target[bi] != target))
            right = 1'b0;
         if (taken && ctr != gbp_pkg::CTR_MAX)
            pht_ctr[pi] = ctr + 2'd1;
         if (!taken && ctr != gbp_pkg::CTR_MIN)
            pht_ctr[pi] = ctr - 2'd1;
         if (taken) begin
            btb_target[bi] = target;
            btb_valid[bi]  = 1'b1;
         end
         ghr = {ghr[gbp_pkg::HIST_BITS-2:0], taken} & hist_mask(hist_len);
      end
      if (!right)
         miss_count = miss_count + gbp_pkg::CNT_BITS'(1);
      res.predicted_right  = right;
      res.branch_count     = seen_count;
      res.mispredict_count = miss_count;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // one request beat; returns in the step of the accepting edge, valid left high
   task automatic send_branch(input logic [gbp_pkg::ADDR_BITS-1:0] pc, input logic taken,
                              input logic [gbp_pkg::ADDR_BITS-1:0] target);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_branch_pc     <= pc;
      req_was_taken     <= taken;
      req_branch_target <= target;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(resolve_branch(pc, taken, target));
   endtask

   // stop sending and let every outstanding result and the last update finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [gbp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gbp_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic perfect,
                            input logic [gbp_pkg::HLEN_BITS-1:0] hlen);
      logic [gbp_pkg::CSR_DATA_W-1:0] junk;
      junk = gbp_pkg::CSR_DATA_W'($urandom);
      wait_idle();
      csr_write(gbp_pkg::CSR_PERFECT_MODE, {junk[gbp_pkg::CSR_DATA_W-1:1], perfect});
      csr_write(gbp_pkg::CSR_HISTORY_LENGTH, gbp_pkg::CSR_DATA_W'(hlen));
   endtask

   // reset config: counter saturation both ways, target compare, address extremes
   task automatic test_directed_corners();
      send_branch(32'h0000_0000, 1'b0, 32'h0000_0000);
      repeat (3) send_branch(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_branch(32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
      repeat (4) send_branch(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
      repeat (2) send_branch(32'h0000_0200, 1'b1, 32'h0000_0000);
      send_branch(32'hAAAA_AAAA, 1'b1, 32'h5555_5555);
   endtask

   // longest history, then a shorter length truncates what is kept
   task automatic test_history_length();
      configure(1'b0, 6'd63);
      repeat (4) send_branch(32'h0000_0F0F, 1'b1, 32'h0000_1000);
      configure(1'b0, 6'd2);
      send_branch(32'h0000_0F0F, 1'b1, 32'h0000_1000);
      send_branch(32'h5555_5555, 1'b0, 32'hAAAA_AAAA);
   endtask

   task automatic test_perfect_mode();
      configure(1'b1, 6'd5);
      send_branch(32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
      send_branch(32'h0000_0200, 1'b1, 32'h1357_9BDF);
      send_branch(32'h0000_0F0F, 1'b0, 32'h0000_1000);
      configure(1'b0, 6'd5);
      send_branch(32'h0000_0200, 1'b1, 32'h0000_0000);
   endtask

   task automatic test_unused_csr_index();
      wait_idle();
      for (int i = CSR_FIRST_UNUSED; i < (1 << gbp_pkg::CSR_IDX_W); i++)
         csr_write(gbp_pkg::CSR_IDX_W'(i), gbp_pkg::CSR_DATA_W'($urandom));
      send_branch(32'h0000_0F0F, 1'b1, 32'h0000_1000);
      send_branch(32'h0000_0200, 1'b1, 32'h0000_0000);
   endtask

   // hot branches with mostly stable targets and biased outcomes, mixed with noise
   task automatic test_random_traffic();
      logic [gbp_pkg::ADDR_BITS-1:0] hot_pc  [HOT_BRANCHES];
      logic [gbp_pkg::ADDR_BITS-1:0] hot_tgt [HOT_BRANCHES];
      int                            hot_bias[HOT_BRANCHES];
      int                            bias_choice[5] = '{0, 5, 50, 95, 100};
      logic [gbp_pkg::HLEN_BITS-1:0] hlen;
      int                            h;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       hlen = '0;
            1:       hlen = 6'd63;
            4:       hlen = 6'd10;
            default: hlen = gbp_pkg::HLEN_BITS'($urandom_range(62, 1));
         endcase
         configure(phase == 3, hlen);
         for (int i = 0; i < HOT_BRANCHES; i++) begin
            if (i > 0 && $urandom_range(3) == 0)
               hot_pc[i] = hot_pc[i-1]
                         ^ (gbp_pkg::ADDR_BITS'($urandom) << gbp_pkg::BTB_IDX_W);
            else
               hot_pc[i] = $urandom;
            hot_tgt[i]  = $urandom;
            hot_bias[i] = bias_choice[$urandom_range(4)];
         end
         for (int n = 0; n < 100; n++) begin
            quiet = (phase % 2 == 0) && n >= 30 && n < 60;
            if (phase == 2 && n == 70)
               wait_idle();
            if ($urandom_range(99) < 75) begin
               h = $urandom_range(HOT_BRANCHES - 1);
               if ($urandom_range(29) == 0)
                  hot_tgt[h] = $urandom;
               send_branch(hot_pc[h], $urandom_range(99) < hot_bias[h], hot_tgt[h]);
            end else begin
               send_branch($urandom, 1'($urandom_range(1)), $urandom);
            end
         end
         quiet = 1'b0;
      end
   endtask

   always @(posedge clock) begin : rsp_scoreboard
      branch_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no branch outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_predicted_right !== want.predicted_right) begin
               $error("predicted_right: expected %0d, got %0d",
                      want.predicted_right, rsp_predicted_right);
               fail_count++;
            end
            if (rsp_branch_count !== want.branch_count) begin
               $error("branch_count: expected %0d, got %0d",
                      want.branch_count, rsp_branch_count);
               fail_count++;
            end
            if (rsp_mispredict_count !== want.mispredict_count) begin
               $error("mispredict_count: expected %0d, got %0d",
                      want.mispredict_count, rsp_mispredict_count);
               fail_count++;
            end
         end
      end
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else if (!quiet && $urandom_range(99) < 15) begin
         rsp_stall = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_branch_pc     <= '0;
      req_was_taken     <= 1'b0;
      req_branch_target <= '0;
      csr_we            <= 1'b0;
      csr_index         <= gbp_pkg::CSR_PERFECT_MODE;
      csr_wdata         <= '0;
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_history_length();
      test_perfect_mode();
      test_unused_csr_index();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
rtl/core/gbp_pkg.sv
rtl/core/gbp_tables.sv
rtl/core/gshare_branch_predictor_btb.sv
tb/tb_gshare_branch_predictor_btb.sv
